// ===== hw/rtl/efp_pkg.sv =====
// Package for the escaped frame target report parser.
// Holds the framing constants, the parser mode type and the CRC-8 step function.
// No dependencies.
package efp_pkg;

	localparam int CAPACITY = 64;
	localparam int LEN_W    = 7;
	localparam int KEEP     = 10;
	localparam int IDX_W    = $clog2(KEEP);
	localparam int CNT_W    = 32;

	localparam logic [7:0] BYTE_HDR    = 8'hFF;
	localparam logic [7:0] BYTE_TAIL   = 8'hFE;
	localparam logic [7:0] BYTE_ESC    = 8'h7D;
	localparam logic [7:0] ESC_HDR     = 8'h5F;
	localparam logic [7:0] ESC_TAIL    = 8'h5E;
	localparam logic [7:0] ESC_ESC     = 8'h5D;
	localparam logic [7:0] FRM_VERSION = 8'h01;
	localparam logic [7:0] FRM_COMMAND = 8'h01;
	localparam logic [7:0] FRM_PAYLEN  = 8'd6;
	localparam logic [7:0] CRC_POLY    = 8'h07;

	localparam logic [LEN_W-1:0] CAP_LEN  = LEN_W'(CAPACITY);
	localparam logic [LEN_W-1:0] KEEP_LEN = LEN_W'(KEEP);
	localparam logic [LEN_W-1:0] CRC_LEN  = LEN_W'(KEEP - 1);

	typedef enum logic [2:0] {
		MODE_HUNT = 3'b001,
		MODE_RECV = 3'b010,
		MODE_ESC  = 3'b100
	} mode_t;

	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== hw/rtl/efp_byte_if.sv =====
// Valid/ready channel carrying one received serial byte per transaction.
// Depends on efp_pkg.
interface efp_byte_if import efp_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== hw/rtl/efp_report_if.sv =====
// Valid/ready channel carrying one target report per transaction.
// Depends on efp_pkg.
interface efp_report_if import efp_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    target_flag;
	logic                    switch_ack_flag;
	logic [7:0]              ack_id;
	logic signed [15:0]      offset_x;
	logic signed [15:0]      offset_y;
	logic [CNT_W-1:0]        report_number;

	modport source (output valid, output target_flag, output switch_ack_flag, output ack_id,
		output offset_x, output offset_y, output report_number, input ready);
	modport sink (input valid, input target_flag, input switch_ack_flag, input ack_id,
		input offset_x, input offset_y, input report_number, output ready);
endinterface

// ===== hw/rtl/escaped_frame_target_report_parser.sv =====
// Top level: byte-stuffed frame parser with CRC-8 check, emits target reports.
// Depends on efp_pkg, efp_byte_if, efp_report_if.
//
//   channel   dir   payload                                            per transaction
//   rx        in    rx_byte                                            one raw byte
//   report    out   target_flag switch_ack_flag ack_id offset_x/y ...  one accepted frame
//
// One byte per cycle while no report stalls: input register, one parse step
// (CRC-8 per byte), result register; a byte is parsed once that register is free.
// arst_n clears the parser mode, frame length, report count and valid flags.
// A stalled report holds the parse stage; the input register still takes one more byte.
module escaped_frame_target_report_parser import efp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	efp_byte_if.sink            rx,
	efp_report_if.source        report
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             advance;
	logic             out_free;

	mode_t            mode_q, mode_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic [7:0]       crc_q;
	logic [7:0]       frame_q [KEEP];
	logic [CNT_W-1:0] count_q;

	logic             add_en;
	logic [7:0]       add_val;
	logic             tail;
	logic             store_en;
	logic             res_ok;

	logic             out_valid_q;
	logic             tgt_q, ack_q;
	logic [7:0]       ack_id_q;
	logic [15:0]      off_x_q, off_y_q;
	logic [CNT_W-1:0] num_q;

	assign out_free = !out_valid_q || report.ready;
	assign advance  = valid_s1 && out_free;
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	always_comb begin
		mode_d  = mode_q;
		len_d   = len_q;
		add_en  = 1'b0;
		add_val = byte_s1;
		tail    = 1'b0;
		unique case (mode_q)
			MODE_HUNT: begin
				if (byte_s1 == BYTE_HDR) begin
					len_d  = '0;
					mode_d = MODE_RECV;
				end
			end
			MODE_ESC: begin
				if (byte_s1 == ESC_HDR) begin
					add_en  = 1'b1;
					add_val = BYTE_HDR;
				end else if (byte_s1 == ESC_TAIL) begin
					add_en  = 1'b1;
					add_val = BYTE_TAIL;
				end else if (byte_s1 == ESC_ESC) begin
					add_en  = 1'b1;
					add_val = BYTE_ESC;
				end else begin
					mode_d = MODE_HUNT;
					len_d  = '0;
				end
			end
			MODE_RECV: begin
				if (byte_s1 == BYTE_ESC) begin
					mode_d = MODE_ESC;
				end else if (byte_s1 == BYTE_TAIL) begin
					tail   = 1'b1;
					mode_d = MODE_HUNT;
					len_d  = '0;
				end else if (byte_s1 == BYTE_HDR) begin
					len_d = '0;
				end else begin
					add_en = 1'b1;
				end
			end
			default: begin
				mode_d = MODE_HUNT;
				len_d  = '0;
			end
		endcase
		if (add_en) begin
			if (len_q < CAP_LEN) begin
				len_d  = len_q + LEN_W'(1);
				mode_d = MODE_RECV;
			end else begin
				mode_d = MODE_HUNT;
				len_d  = '0;
			end
		end
	end

	assign store_en = add_en && (len_q < CAP_LEN) && (len_q < KEEP_LEN);

	assign res_ok = tail && (len_q == KEEP_LEN)
		&& (frame_q[0] == FRM_VERSION) && (frame_q[1] == FRM_COMMAND)
		&& (frame_q[2] == FRM_PAYLEN) && (crc_q == frame_q[KEEP-1])
		&& (frame_q[3][7:2] == 6'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_HUNT;
			len_q   <= '0;
			count_q <= '0;
		end else if (advance) begin
			mode_q <= mode_d;
			len_q  <= len_d;
			if (res_ok) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	// frame bytes and running CRC over the first nine; first byte restarts the CRC
	always_ff @(posedge clk) begin
		if (advance && store_en) begin
			frame_q[len_q[IDX_W-1:0]] <= add_val;
			if (len_q < CRC_LEN) begin
				crc_q <= crc8_step((len_q == '0) ? 8'h00 : crc_q, add_val);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_ok;
		end else if (report.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_ok) begin
			tgt_q    <= frame_q[3][0];
			ack_q    <= frame_q[3][1];
			ack_id_q <= frame_q[3][1] ? frame_q[8] : 8'h00;
			off_x_q  <= frame_q[3][0] ? {frame_q[5], frame_q[4]} : 16'h0000;
			off_y_q  <= frame_q[3][0] ? {frame_q[7], frame_q[6]} : 16'h0000;
			num_q    <= count_q + CNT_W'(1);
		end
	end

	assign report.valid           = out_valid_q;
	assign report.target_flag     = tgt_q;
	assign report.switch_ack_flag = ack_q;
	assign report.ack_id          = ack_id_q;
	assign report.offset_x        = off_x_q;
	assign report.offset_y        = off_y_q;
	assign report.report_number   = num_q;

endmodule

// ===== test/efp_tb_pkg.sv =====
// Shared testbench types for the escaped frame parser: target report record and CRC-8 update.
// Depends on efp_pkg.
package efp_tb_pkg;
	import efp_pkg::*;

	typedef struct packed {
		logic             target_flag;
		logic             switch_ack_flag;
		logic [7:0]       ack_id;
		logic [15:0]      offset_x;
		logic [15:0]      offset_y;
		logic [CNT_W-1:0] report_number;
	} target_report_t;

	// bit-serial form, MSB first
	function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] r;
		logic       fb;
		r = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = r[7] ^ data[i];
			r = {r[6:0], 1'b0};
			if (fb) begin
				r = r ^ CRC_POLY;
			end
		end
		return r;
	endfunction

endpackage

// ===== test/efp_report_checker.sv =====
// Report checker: tracks the deframer state from accepted bytes, predicts target reports
// and compares them with the report channel. Depends on efp_pkg, efp_tb_pkg, both interfaces.
module efp_report_checker import efp_pkg::*, efp_tb_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	efp_byte_if   rx,
	efp_report_if report,
	output int    errors,
	output int    pending,
	output int    reports_seen
);

	mode_t            parse_state;
	logic [LEN_W-1:0] frame_len;
	logic [7:0]       frame_bytes [KEEP];
	logic [CNT_W-1:0] accepted_count;
	target_report_t   expected_reports [$];
	int               mismatch_count;
	int               checked_count;

	task automatic drop_frame();
		parse_state = MODE_HUNT;
		frame_len = '0;
	endtask

	task automatic push_logical(input logic [7:0] b);
		if (frame_len < CAP_LEN) begin
			if (frame_len < KEEP_LEN) begin
				frame_bytes[frame_len[IDX_W-1:0]] = b;
			end
			frame_len = frame_len + LEN_W'(1);
			parse_state = MODE_RECV;
		end else begin
			drop_frame();
		end
	endtask

	task automatic finish_frame();
		logic [7:0]     crc;
		target_report_t r;
		crc = '0;
		if (frame_len != KEEP_LEN) return;
		if (frame_bytes[0] != FRM_VERSION || frame_bytes[1] != FRM_COMMAND ||
			frame_bytes[2] != FRM_PAYLEN) return;
		for (int i = 0; i < KEEP - 1; i++) begin
			crc = crc8_next(crc, frame_bytes[i]);
		end
		if (crc != frame_bytes[KEEP-1]) return;
		if (frame_bytes[3][7:2] != '0) return;
		accepted_count = accepted_count + CNT_W'(1);
		r.target_flag = frame_bytes[3][0];
		r.switch_ack_flag = frame_bytes[3][1];
		r.ack_id = r.switch_ack_flag ? frame_bytes[8] : '0;
		r.offset_x = r.target_flag ? {frame_bytes[5], frame_bytes[4]} : '0;
		r.offset_y = r.target_flag ? {frame_bytes[7], frame_bytes[6]} : '0;
		r.report_number = accepted_count;
		expected_reports.push_back(r);
	endtask

	task automatic advance_parser(input logic [7:0] b);
		case (parse_state)
			MODE_HUNT: begin
				if (b == BYTE_HDR) begin
					frame_len = '0;
					parse_state = MODE_RECV;
				end
			end
			MODE_ESC: begin
				case (b)
					ESC_HDR:  push_logical(BYTE_HDR);
					ESC_TAIL: push_logical(BYTE_TAIL);
					ESC_ESC:  push_logical(BYTE_ESC);
					default:  drop_frame();
				endcase
			end
			default: begin
				parse_state = MODE_RECV;
				if (b == BYTE_ESC) begin
					parse_state = MODE_ESC;
				end else if (b == BYTE_TAIL) begin
					finish_frame();
					drop_frame();
				end else if (b == BYTE_HDR) begin
					frame_len = '0;
				end else begin
					push_logical(b);
				end
			end
		endcase
	endtask

	task automatic check_report();
		target_report_t want;
		if (expected_reports.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= 10) begin
				$display("unexpected report: tgt=%0b ack=%0b id=%02h x=%0d y=%0d n=%0d",
					report.target_flag, report.switch_ack_flag, report.ack_id,
					report.offset_x, report.offset_y, report.report_number);
			end
		end else begin
			want = expected_reports.pop_front();
			checked_count++;
			if (report.target_flag !== want.target_flag ||
				report.switch_ack_flag !== want.switch_ack_flag ||
				report.ack_id !== want.ack_id || report.offset_x !== want.offset_x ||
				report.offset_y !== want.offset_y ||
				report.report_number !== want.report_number) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("report mismatch: expected tgt=%0b ack=%0b id=%02h x=%0d y=%0d n=%0d",
						want.target_flag, want.switch_ack_flag, want.ack_id,
						$signed(want.offset_x), $signed(want.offset_y), want.report_number);
					$display("                 actual   tgt=%0b ack=%0b id=%02h x=%0d y=%0d n=%0d",
						report.target_flag, report.switch_ack_flag, report.ack_id,
						report.offset_x, report.offset_y, report.report_number);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parse_state = MODE_HUNT;
			frame_len = '0;
			accepted_count = '0;
			foreach (frame_bytes[i]) frame_bytes[i] = '0;
			expected_reports.delete();
			mismatch_count = 0;
			checked_count = 0;
		end else begin
			if (report.valid && report.ready) begin
				check_report();
			end
			if (rx.valid && rx.ready) begin
				advance_parser(rx.rx_byte);
			end
		end
		errors <= mismatch_count;
		pending <= expected_reports.size();
		reports_seen <= checked_count;
	end

endmodule

// ===== test/tb_top.sv =====
// Testbench top for the escaped frame parser: clock, reset, byte stimulus and report backpressure.
// Depends on efp_pkg, efp_tb_pkg, efp_byte_if, efp_report_if and efp_report_checker.
module tb_top;
	import efp_pkg::*;
	import efp_tb_pkg::*;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	int         src_idle_pct = 26;
	int         sink_idle_pct = 62;
	int         bytes_sent = 0;
	int         mismatches;
	int         waiting;
	int         reports_seen;
	logic [7:0] frame_data [$];

	efp_byte_if   rx_ch ();
	efp_report_if report_ch ();

	escaped_frame_target_report_parser dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.report (report_ch)
	);

	efp_report_checker u_report_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx           (rx_ch),
		.report       (report_ch),
		.errors       (mismatches),
		.pending      (waiting),
		.reports_seen (reports_seen)
	);

	always #2 clk = ~clk;

	always @(negedge clk) begin
		report_ch.ready <= arst_n && ($urandom_range(99) >= sink_idle_pct);
	end

	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

	// called at a falling edge, returns at the falling edge after the transaction
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < src_idle_pct) begin
			rx_ch.valid <= 1'b0;
			@(negedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		do @(posedge clk); while (!rx_ch.ready);
		@(negedge clk);
		bytes_sent++;
	endtask

	task automatic send_logical(input logic [7:0] b);
		case (b)
			BYTE_HDR: begin
				send_byte(BYTE_ESC);
				send_byte(ESC_HDR);
			end
			BYTE_TAIL: begin
				send_byte(BYTE_ESC);
				send_byte(ESC_TAIL);
			end
			BYTE_ESC: begin
				send_byte(BYTE_ESC);
				send_byte(ESC_ESC);
			end
			default: send_byte(b);
		endcase
	endtask

	task automatic send_frame();
		send_byte(BYTE_HDR);
		foreach (frame_data[i]) send_logical(frame_data[i]);
		send_byte(BYTE_TAIL);
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(15))
			0:       return BYTE_HDR;
			1:       return BYTE_TAIL;
			2:       return BYTE_ESC;
			3:       return 8'h00;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// appends the check byte over the first nine bytes
	task automatic seal_crc();
		logic [7:0] crc;
		crc = '0;
		for (int i = 0; i < KEEP - 1; i++) begin
			crc = crc8_next(crc, frame_data[i]);
		end
		frame_data.push_back(crc);
	endtask

	task automatic build_report(input logic [7:0] flags);
		frame_data = '{FRM_VERSION, FRM_COMMAND, FRM_PAYLEN, flags};
		repeat (5) frame_data.push_back(pick_byte());
		seal_crc();
	endtask

	task automatic send_random_frame();
		int         kind;
		int         n;
		int         idx;
		logic [7:0] b;
		kind = $urandom_range(99);
		build_report(8'($urandom_range(3)));
		if (kind < 50) begin
			send_frame();
		end else if (kind < 56) begin
			// bad header or reserved flag bits, check byte still correct
			void'(frame_data.pop_back());
			idx = $urandom_range(3);
			if (idx == 3) begin
				frame_data[3][$urandom_range(7, 2)] = 1'b1;
			end else begin
				frame_data[idx] = frame_data[idx] ^ 8'($urandom_range(255, 1));
			end
			seal_crc();
			send_frame();
		end else if (kind < 61) begin
			idx = $urandom_range(KEEP - 1);
			frame_data[idx] = frame_data[idx] ^ 8'($urandom_range(255, 1));
			send_frame();
		end else if (kind < 66) begin
			n = $urandom_range(20);
			if (n == KEEP) n = KEEP + 1;
			while (frame_data.size() > n) void'(frame_data.pop_back());
			while (frame_data.size() < n) frame_data.push_back(pick_byte());
			send_frame();
		end else if (kind < 72) begin
			// illegal escape drops the frame, a good one follows
			send_byte(BYTE_HDR);
			repeat ($urandom_range(12)) send_logical(pick_byte());
			send_byte(BYTE_ESC);
			case ($urandom_range(3))
				0: b = BYTE_HDR;
				1: b = BYTE_TAIL;
				default: begin
					b = 8'($urandom_range(255));
					if (b == ESC_HDR || b == ESC_TAIL || b == ESC_ESC) b = 8'h00;
				end
			endcase
			send_byte(b);
			send_frame();
		end else if (kind < 80) begin
			// partial frame restarted by a fresh header
			send_byte(BYTE_HDR);
			repeat ($urandom_range(12)) send_logical(pick_byte());
			send_frame();
		end else if (kind < 84) begin
			// around the capacity limit
			send_byte(BYTE_HDR);
			repeat ($urandom_range(CAPACITY - 2, CAPACITY + 2)) send_logical(pick_byte());
			send_byte(BYTE_TAIL);
		end else begin
			repeat ($urandom_range(1, 6)) send_byte(pick_byte());
		end
	endtask

	initial begin
		int drain;
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// ignored while hunting, then a header restarted by another header
		send_byte(8'h00);
		send_byte(BYTE_TAIL);
		send_byte(BYTE_ESC);
		send_byte(BYTE_HDR);
		send_byte(FRM_VERSION);
		// target and acknowledge, every escape, offset_x at the positive extreme, offset_y negative
		frame_data = '{FRM_VERSION, FRM_COMMAND, FRM_PAYLEN, 8'h03,
			8'hFF, 8'h7F, 8'hFE, 8'h80, 8'h7D};
		seal_crc();
		send_frame();
		send_byte(BYTE_HDR);
		send_byte(BYTE_ESC);
		send_byte(8'h00);

		for (int stage = 0; stage < 3; stage++) begin
			case (stage)
				0: begin
					src_idle_pct = 26;
					sink_idle_pct = 62;
				end
				1: begin
					src_idle_pct = 62;
					sink_idle_pct = 26;
				end
				default: begin
					src_idle_pct = 0;
					sink_idle_pct = 0;
				end
			endcase
			while (bytes_sent < (stage + 1) * 650) send_random_frame();
		end
		rx_ch.valid <= 1'b0;

		drain = 0;
		while (waiting != 0 && drain < 1000) begin
			@(posedge clk);
			drain++;
		end
		repeat (8) @(posedge clk);

		$display("Drove %0d serial bytes under three backpressure patterns;", bytes_sent);
		$display("%0d target reports compared, %0d mismatches, %0d outstanding.",
			reports_seen, mismatches, waiting);
		if (mismatches == 0 && waiting == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
